@@ design/mtm_pkg.sv @@
`default_nettype none
package mtm_pkg;

  typedef enum logic [1:0] {
    REQ_SIDE   = 2'd0,
    REQ_MIDDLE = 2'd1,
    REQ_RUN    = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  localparam logic [2:0] CFG_SIZE_TOL  = 3'd0;
  localparam logic [2:0] CFG_RATIO_TOL = 3'd1;
  localparam logic [2:0] CFG_DIFF_TOL  = 3'd2;
  localparam logic [2:0] CFG_DIST_LIM  = 3'd3;
  localparam logic [2:0] CFG_WIDTH     = 3'd4;
  localparam logic [2:0] CFG_HEIGHT    = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [15:0] blob_size;
  } req_beat_t;

  typedef struct packed {
    logic [7:0]         match_count;
    logic               single_marker;
    logic signed [11:0] offset_x;
    logic signed [11:0] offset_y;
    logic [3:0]         first_side_index;
    logic [3:0]         second_side_index;
    logic [3:0]         middle_index;
    logic               load_overflow;
  } rsp_beat_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [12:0] data;
  } cfg_beat_t;

endpackage
`default_nettype wire

@@ design/marker_triple_matcher_core.sv @@
// Channel | dir | payload    | handshake
// req     | in  | req_beat_t | req_valid / req_ready
// rsp     | out | rsp_beat_t | rsp_valid / rsp_ready
// cfg     | in  | cfg_beat_t | cfg_valid / cfg_ready (always ready)
// A load is accepted, then written. A run walks every (i<j, k) triple through
// a shared square-root unit, one square-root digit per cycle, and a shared
// compare unit doing a few compare steps, each compare one 12x17 multiply.
// Each pair is fetched, size-checked and advanced, with the side-to-side
// distance taken when sizes agree; each middle blob adds two distances and checks.
// Reset (rst, synchronous) empties both lists and loads register defaults.
// A finished result waits in the output register; loads still go on, and the
// next run holds in its last step until the waiting beat is taken.
`default_nettype none
module marker_triple_matcher_core #(
  parameter int MAX_SIDE_POINTS   = 16,
  parameter int MAX_MIDDLE_POINTS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_ready,
  input  mtm_pkg::req_beat_t   req,
  output logic                 rsp_valid,
  input  wire                  rsp_ready,
  output mtm_pkg::rsp_beat_t   rsp,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  mtm_pkg::cfg_beat_t   cfg
);
  import mtm_pkg::*;

  localparam int SW = (MAX_SIDE_POINTS > 1) ? $clog2(MAX_SIDE_POINTS) : 1;
  localparam int MW = (MAX_MIDDLE_POINTS > 1) ? $clog2(MAX_MIDDLE_POINTS) : 1;
  localparam int SCW = $clog2(MAX_SIDE_POINTS + 1);
  localparam int MCW = $clog2(MAX_MIDDLE_POINTS + 1);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_LOAD  = 14'b00000000000010,
    ST_PAIR  = 14'b00000000000100,
    ST_SZ    = 14'b00000000001000,
    ST_DD    = 14'b00000000010000,
    ST_MID   = 14'b00000000100000,
    ST_D1    = 14'b00000001000000,
    ST_D2    = 14'b00000010000000,
    ST_CHK   = 14'b00000100000000,
    ST_NEXT  = 14'b00001000000000,
    ST_OFS   = 14'b00010000000000,
    ST_DONE  = 14'b00100000000000,
    ST_SQRT  = 14'b01000000000000,
    ST_HOLD  = 14'b10000000000000
  } state_t;

  state_t state, ret;

  // configuration
  logic [7:0]  size_tol, ratio_tol, diff_tol;
  logic [11:0] dist_lim;
  logic [12:0] img_w, img_h;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      size_tol <= 8'd102; ratio_tol <= 8'd102; diff_tol <= 8'd26;
      dist_lim <= 12'd896; img_w <= 13'd640; img_h <= 13'd480;
    end else if (cfg_valid) begin
      case (cfg.index)
        CFG_SIZE_TOL:  size_tol  <= cfg.data[7:0];
        CFG_RATIO_TOL: ratio_tol <= cfg.data[7:0];
        CFG_DIFF_TOL:  diff_tol  <= cfg.data[7:0];
        CFG_DIST_LIM:  dist_lim  <= cfg.data[11:0];
        CFG_WIDTH:     img_w     <= cfg.data;
        CFG_HEIGHT:    img_h     <= cfg.data;
        default: ;
      endcase
    end
  end

  // blob memories
  logic [47:0] side_mem [MAX_SIDE_POINTS];
  logic [47:0] mid_mem  [MAX_MIDDLE_POINTS];
  logic [47:0] s_rd, m_rd;
  logic [SW-1:0] s_addr;
  logic [MW-1:0] m_addr;
  logic s_we, m_we;
  logic [SW-1:0] s_waddr;
  logic [MW-1:0] m_waddr;
  logic [47:0] wdata;

  always_ff @(posedge clk) begin
    if (s_we) side_mem[s_waddr] <= wdata;
    s_rd <= side_mem[s_addr];
  end
  always_ff @(posedge clk) begin
    if (m_we) mid_mem[m_waddr] <= wdata;
    m_rd <= mid_mem[m_addr];
  end

  logic [SCW-1:0] side_count;
  logic [MCW-1:0] mid_count;
  logic           ovf;
  req_beat_t      lreq;
  logic [SW-1:0]  ii, jj;
  logic [MW-1:0]  kk;
  logic [47:0]    s1, s2, mb;
  logic [16:0]    dd, d1, d2;
  logic [7:0]     count;
  logic [SW-1:0]  li, lj;
  logic [MW-1:0]  lk;
  logic [15:0]    lmx, lmy;
  logic [3:0]     chk;
  logic           fail;
  logic [1:0]     sq_sel;

  // shared square-root unit: one result bit per cycle
  logic [33:0] sq_rem;
  logic [33:0] sq_root;
  logic [4:0]  sq_cnt;
  logic [33:0] sq_trial, sq_shift;

  // shared compare unit: a*256 > tol*b, or b zero where the zero check is on
  logic [24:0] cmp_a;
  logic [16:0] cmp_b;
  logic [11:0] cmp_t;
  logic [32:0] cmp_lhs, cmp_rhs;
  logic        cmp_gt;
  logic        cmp_bz;

  function automatic logic [16:0] adiff(input logic [16:0] a, input logic [16:0] b);
    adiff = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [33:0] sqd(input logic [47:0] a, input logic [47:0] b);
    logic [15:0] dx, dy;
    logic [31:0] px, py;
    dx = (a[47:32] > b[47:32]) ? a[47:32] - b[47:32] : b[47:32] - a[47:32];
    dy = (a[31:16] > b[31:16]) ? a[31:16] - b[31:16] : b[31:16] - a[31:16];
    px = dx * dx;
    py = dy * dy;
    sqd = {2'b0, px} + {2'b0, py};
  endfunction

  always_comb begin
    cmp_a = '0; cmp_b = '0; cmp_t = '0; cmp_bz = 1'b0;
    case (chk)
      4'd0: begin cmp_a = {8'd0, adiff({1'b0, s1[15:0]}, {1'b0, s2[15:0]})};
        cmp_b = {1'b0, s2[15:0]}; cmp_t = {4'd0, size_tol}; cmp_bz = 1'b1; end
      4'd1: begin cmp_a = {8'd0, adiff(d1, d2)}; cmp_b = d2;
        cmp_t = {4'd0, ratio_tol}; cmp_bz = 1'b1; end
      4'd2: begin cmp_a = {7'd0, ((d1 + d2 > {1'b0, dd}) ? d1 + d2 - {1'b0, dd}
                                       : {1'b0, dd} - (d1 + d2))};
        cmp_b = dd; cmp_t = {4'd0, diff_tol}; cmp_bz = 1'b1; end
      4'd3: begin cmp_a = {8'd0, adiff({1'b0, mb[15:0]}, {1'b0, s1[15:0]})};
        cmp_b = {1'b0, s1[15:0]}; cmp_t = {4'd0, size_tol}; cmp_bz = 1'b1; end
      4'd4: begin cmp_a = {8'd0, adiff({1'b0, mb[15:0]}, {1'b0, s2[15:0]})};
        cmp_b = {1'b0, s2[15:0]}; cmp_t = {4'd0, size_tol}; cmp_bz = 1'b1; end
      4'd5: begin cmp_a = {8'd0, d1}; cmp_b = {1'b0, mb[15:0]}; cmp_t = dist_lim;
        cmp_bz = 1'b1; end
      4'd6: begin cmp_a = {8'd0, d2}; cmp_b = {1'b0, mb[15:0]}; cmp_t = dist_lim; end
      default: ;
    endcase
    cmp_lhs = {cmp_a, 8'd0};
    cmp_rhs = {4'd0, cmp_t} * {16'd0, cmp_b};
    cmp_gt  = (cmp_lhs > cmp_rhs) || (cmp_bz && cmp_b == '0);
  end

  assign sq_trial = sq_root + sq_shift;
  assign sq_shift = 34'd1 << {sq_cnt, 1'b0};

  // offsets: truncate toward zero then saturate
  function automatic logic [11:0] ofs(input logic signed [19:0] n);
    logic signed [19:0] q;
    q = (n >= 0) ? (n >>> 4) : -((-n) >>> 4);
    if (q > 20'sd2047) ofs = 12'h7FF;
    else if (q < -20'sd2048) ofs = 12'h800;
    else ofs = q[11:0];
  endfunction

  logic signed [19:0] nx, ny;
  assign nx = $signed({4'd0, lmx}) - $signed({3'd0, img_w[12:1], 4'd0});
  assign ny = $signed({3'd0, img_h[12:1], 4'd0}) - $signed({4'd0, lmy});

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    s_we = 1'b0; m_we = 1'b0;
    s_waddr = side_count[SW-1:0]; m_waddr = mid_count[MW-1:0];
    wdata = {lreq.point_x, lreq.point_y, lreq.blob_size};
    if (state == ST_LOAD) begin
      s_we = (lreq.req_type == REQ_SIDE) && (side_count < SCW'(MAX_SIDE_POINTS));
      m_we = (lreq.req_type == REQ_MIDDLE) && (mid_count < MCW'(MAX_MIDDLE_POINTS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; ret <= ST_IDLE;
      side_count <= '0; mid_count <= '0; ovf <= 1'b0; rsp_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      case (state)
        ST_IDLE: if (req_valid && req_ready) begin
          lreq <= req;
          if (req.req_type == REQ_RUN) begin
            ii <= '0; jj <= SW'(1); count <= '0; li <= '0; lj <= '0; lk <= '0;
            if (side_count >= SCW'(2)) state <= ST_PAIR;
            else state <= ST_DONE;
          end else state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (lreq.req_type == REQ_SIDE) begin
            if (side_count < SCW'(MAX_SIDE_POINTS)) side_count <= side_count + 1'b1;
            else ovf <= 1'b1;
          end else if (lreq.req_type == REQ_MIDDLE) begin
            if (mid_count < MCW'(MAX_MIDDLE_POINTS)) mid_count <= mid_count + 1'b1;
            else ovf <= 1'b1;
          end
          state <= ST_IDLE;
        end
        ST_PAIR: begin
          s_addr <= ii; state <= ST_HOLD;
        end
        ST_HOLD: begin
          // s1 read is under way; fetch s2
          s_addr <= jj; state <= ST_SZ; chk <= 4'd15;
        end
        ST_SZ: begin
          if (chk == 4'd15) begin s1 <= s_rd; chk <= 4'd14; end
          else if (chk == 4'd14) begin s2 <= s_rd; chk <= 4'd0; end
          else begin
            if (cmp_gt) state <= ST_NEXT;
            else begin
              sq_sel <= 2'd0; sq_root <= '0; sq_rem <= sqd(s1, s2);
              sq_cnt <= 5'd16; ret <= ST_DD; state <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if (sq_rem >= sq_trial) begin
            sq_rem <= sq_rem - sq_trial;
            sq_root <= (sq_root >> 1) + sq_shift;
          end else sq_root <= sq_root >> 1;
          if (sq_cnt == 5'd0) state <= ret;
          else sq_cnt <= sq_cnt - 1'b1;
        end
        ST_DD: begin
          case (sq_sel)
            2'd0: begin dd <= sq_root[16:0]; kk <= '0;
              if (mid_count == '0) state <= ST_NEXT;
              else begin m_addr <= '0; state <= ST_MID; chk <= 4'd15; end end
            2'd1: begin d1 <= sq_root[16:0]; sq_sel <= 2'd2; sq_root <= '0;
              sq_rem <= sqd(s2, mb); sq_cnt <= 5'd16; ret <= ST_DD; state <= ST_SQRT; end
            default: begin d2 <= sq_root[16:0]; chk <= 4'd1; fail <= 1'b0;
              state <= ST_CHK; end
          endcase
        end
        ST_MID: begin
          if (chk == 4'd15) chk <= 4'd14;
          else begin
            mb <= m_rd; sq_sel <= 2'd1; sq_root <= '0; sq_rem <= sqd(s1, m_rd);
            sq_cnt <= 5'd16; ret <= ST_DD; state <= ST_SQRT;
          end
        end
        ST_CHK: begin
          if (cmp_gt) fail <= 1'b1;
          if (chk == 4'd6) begin
            if (!fail && !cmp_gt) begin
              if (count != 8'hFF) count <= count + 1'b1;
              li <= ii; lj <= jj; lk <= kk; lmx <= mb[47:32]; lmy <= mb[31:16];
            end
            if ({1'b0, kk} + 1'b1 < MCW'(mid_count)) begin
              kk <= kk + 1'b1; m_addr <= kk + 1'b1; chk <= 4'd15; state <= ST_MID;
            end else state <= ST_NEXT;
          end else chk <= chk + 1'b1;
        end
        ST_NEXT: begin
          if (SCW'(jj) + 1'b1 < side_count) begin
            jj <= jj + 1'b1; state <= ST_PAIR;
          end else if (SCW'(ii) + 2'd2 < side_count) begin
            ii <= ii + 1'b1; jj <= ii + 2'd2; state <= ST_PAIR;
          end else state <= ST_OFS;
        end
        ST_OFS: state <= ST_DONE;
        ST_DONE: begin
          // hold until the previous beat has left the output register
          if (!rsp_valid || rsp_ready) begin
            rsp.match_count <= count;
            rsp.single_marker <= (count == 8'd1);
            rsp.offset_x <= (count == 8'd1) ? ofs(nx) : '0;
            rsp.offset_y <= (count == 8'd1) ? ofs(ny) : '0;
            rsp.first_side_index <= 4'(li);
            rsp.second_side_index <= 4'(lj);
            rsp.middle_index <= 4'(lk);
            rsp.load_overflow <= ovf;
            if (count == 8'd1) begin side_count <= '0; mid_count <= '0; ovf <= 1'b0; end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("rsp dropped");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> state == ST_IDLE) else $error("ready outside idle");
  a_count: assert property (@(posedge clk) disable iff (rst)
    side_count <= SCW'(MAX_SIDE_POINTS) && mid_count <= MCW'(MAX_MIDDLE_POINTS))
    else $error("count beyond capacity");
  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.single_marker == (rsp.match_count == 8'd1))
    else $error("single flag mismatch");
endmodule
`default_nettype wire
